@@ hw/rtl/bspu_pkg.sv @@
// Shared types and constants for the BMP scanline pixel unpacker.
// No dependencies; the front end, back end and top level refer to this package by scoped name.
package bspu_pkg;

	localparam int MAX_WIDTH_DEF     = 4096;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int DIM_W             = 13;
	localparam int CMD_DEPTH         = 4;
	localparam int OUT_DEPTH         = 2;

	typedef enum logic [1:0] {
		MODE_1BPP  = 2'd0,
		MODE_4BPP  = 2'd1,
		MODE_8BPP  = 2'd2,
		MODE_24BPP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_PAL_WR  = 2'd0,
		ACT_DATA    = 2'd1,
		ACT_RESTART = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		CMD_PAL_WR = 3'd0,
		CMD_MONO   = 3'd1,
		CMD_NIB    = 3'd2,
		CMD_IDX    = 3'd3,
		CMD_RGB    = 3'd4,
		CMD_EXCESS = 3'd5
	} cmd_kind_t;

	localparam logic [1:0] REG_DEPTH_MODE = 2'd0;
	localparam logic [1:0] REG_WIDTH      = 2'd1;
	localparam logic [1:0] REG_HEIGHT     = 2'd2;

	localparam mode_t            MODE_RESET   = MODE_8BPP;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

	// effective configuration: mode, plus width and height already clamped
	typedef struct packed {
		mode_t            mode;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	// one unit of work for the back end
	typedef struct packed {
		cmd_kind_t        kind;
		logic [23:0]      data;
		logic [7:0]       index;
		logic [DIM_W-1:0] col;
		logic [3:0]       count;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [11:0] x;
		logic        row_end;
		logic        excess;
		logic        last;
	} res_t;

endpackage

@@ hw/rtl/bspu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the palette store.
module bspu_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/bspu_fifo.sv @@
// Small register-based FIFO, data taken from the head entry.
// No package dependency; used for the command queue and the result buffer.
module bspu_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  wdata,
	input  logic          pop,
	output logic [W-1:0]  rdata,
	output logic          empty,
	output logic          full,
	output logic [CW-1:0] count
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;

	assign rdata = mem_q[rptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/bspu_front.sv @@
// Front end: accepts input items, tracks row/column/row-count state and
// turns each item into at most one back-end command. Depends on bspu_pkg.
module bspu_front #(
	parameter int MAX_WIDTH     = bspu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = bspu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bspu_pkg::cfg_t   cfg,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [1:0]       action,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       palette_index,
	input  logic [23:0]      palette_color,
	output logic             cmd_push,
	output bspu_pkg::cmd_t   cmd,
	input  logic             cmd_full
);

	localparam int DIM_W   = bspu_pkg::DIM_W;
	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam int EFF_MAX = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
	localparam int POS_W   = $clog2(EFF_MAX * 3 + 4);

	logic [DIM_W-1:0] col_q, col_d;
	logic [POS_W-1:0] rowpos_q, rowpos_d;
	logic [DIM_W-1:0] rowcnt_q, rowcnt_d;
	logic [15:0]      partial_q, partial_d;
	logic [1:0]       phase_q, phase_d;

	logic [DIM_W:0]   w14;
	logic [DIM_W+1:0] w15;
	logic [POS_W-1:0] data_len, dl_p3, padded;
	logic [POS_W:0]   pos_inc;
	logic [DIM_W-1:0] remain;
	logic [3:0]       cap, n;
	logic             in_data, excess, accept;

	assign item_ready = !cmd_full;
	assign accept     = item_valid && item_ready;

	always_comb begin
		w14 = {1'b0, cfg.width};
		w15 = {2'b00, cfg.width};
		unique case (cfg.mode)
			bspu_pkg::MODE_1BPP: begin
				data_len = POS_W'((w14 + (DIM_W+1)'(7)) >> 3);
				cap      = 4'd8;
			end
			bspu_pkg::MODE_4BPP: begin
				data_len = POS_W'((w14 + (DIM_W+1)'(1)) >> 1);
				cap      = 4'd2;
			end
			bspu_pkg::MODE_8BPP: begin
				data_len = POS_W'(w14);
				cap      = 4'd1;
			end
			bspu_pkg::MODE_24BPP: begin
				data_len = POS_W'((w15 << 1) + w15);
				cap      = (phase_q == 2'd2) ? 4'd1 : 4'd0;
			end
		endcase
		dl_p3   = data_len + POS_W'(3);
		padded  = {dl_p3[POS_W-1:2], 2'b00};
		// column can sit past the width after a mid-row width change
		remain  = (col_q < cfg.width) ? cfg.width - col_q : '0;
		n       = (remain < {{(DIM_W-4){1'b0}}, cap}) ? remain[3:0] : cap;
		in_data = rowpos_q < data_len;
		excess  = rowcnt_q >= cfg.height;
		pos_inc = {1'b0, rowpos_q} + (POS_W+1)'(1);

		col_d     = col_q;
		rowpos_d  = rowpos_q;
		rowcnt_d  = rowcnt_q;
		partial_d = partial_q;
		phase_d   = phase_q;
		cmd_push  = 1'b0;
		cmd       = '0;

		if (accept) begin
			unique case (action)
				bspu_pkg::ACT_PAL_WR: begin
					if (int'(palette_index) < PALETTE_DEPTH) begin
						cmd_push  = 1'b1;
						cmd.kind  = bspu_pkg::CMD_PAL_WR;
						cmd.data  = palette_color;
						cmd.index = palette_index;
					end
				end
				bspu_pkg::ACT_DATA: begin
					if (excess) begin
						cmd_push  = 1'b1;
						cmd.kind  = bspu_pkg::CMD_EXCESS;
						cmd.count = 4'd1;
					end else begin
						if (in_data) begin
							col_d     = col_q + {{(DIM_W-4){1'b0}}, n};
							cmd_push  = (n != 4'd0);
							cmd.col   = col_q;
							cmd.count = n;
							cmd.data  = {16'h0000, data_byte};
							unique case (cfg.mode)
								bspu_pkg::MODE_1BPP:  cmd.kind = bspu_pkg::CMD_MONO;
								bspu_pkg::MODE_4BPP:  cmd.kind = bspu_pkg::CMD_NIB;
								bspu_pkg::MODE_8BPP:  cmd.kind = bspu_pkg::CMD_IDX;
								bspu_pkg::MODE_24BPP: cmd.kind = bspu_pkg::CMD_RGB;
							endcase
							if (cfg.mode == bspu_pkg::MODE_24BPP) begin
								cmd.data = {data_byte, partial_q};
								if (phase_q == 2'd0) begin
									partial_d = {8'h00, data_byte};
									phase_d   = 2'd1;
								end else if (phase_q == 2'd1) begin
									partial_d = {data_byte, partial_q[7:0]};
									phase_d   = 2'd2;
								end else begin
									partial_d = '0;
									phase_d   = 2'd0;
								end
							end
						end
						if (pos_inc >= {1'b0, padded}) begin
							rowpos_d  = '0;
							col_d     = '0;
							partial_d = '0;
							phase_d   = 2'd0;
							rowcnt_d  = rowcnt_q + DIM_W'(1);
						end else begin
							rowpos_d = pos_inc[POS_W-1:0];
						end
					end
				end
				bspu_pkg::ACT_RESTART: begin
					col_d     = '0;
					rowpos_d  = '0;
					rowcnt_d  = '0;
					partial_d = '0;
					phase_d   = 2'd0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			rowpos_q  <= '0;
			rowcnt_q  <= '0;
			partial_q <= '0;
			phase_q   <= 2'd0;
		end else begin
			col_q     <= col_d;
			rowpos_q  <= rowpos_d;
			rowcnt_q  <= rowcnt_d;
			partial_q <= partial_d;
			phase_q   <= phase_d;
		end
	end

`ifndef SYNTHESIS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("24-bit gather phase out of range");
	a_col_le_width: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.kind != bspu_pkg::CMD_PAL_WR && cmd.kind != bspu_pkg::CMD_EXCESS
		|-> ({1'b0, cmd.col} + {{(DIM_W-3){1'b0}}, cmd.count}) <= {1'b0, cfg.width})
		else $error("pixel run extends past the row");
	a_excess_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && cmd.kind == bspu_pkg::CMD_EXCESS |=> $stable(rowcnt_q) && $stable(rowpos_q))
		else $error("excess byte moved the row state");
`endif

endmodule

@@ hw/rtl/bspu_back.sv @@
// Back end: executes queued commands, one result per cycle while the result buffer
// has room, using the palette RAM, and buffers results for the output channel.
// Depends on bspu_pkg, bspu_ram and bspu_fifo.
module bspu_back #(
	parameter int PALETTE_DEPTH = bspu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bspu_pkg::cfg_t cfg,
	input  logic           head_valid,
	input  bspu_pkg::cmd_t head,
	output logic           head_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output bspu_pkg::res_t res
);

	localparam int AW    = $clog2(PALETTE_DEPTH);
	localparam int DIM_W = bspu_pkg::DIM_W;
	localparam int OCW   = $clog2(bspu_pkg::OUT_DEPTH + 1);

	logic [2:0]       sub_q;
	logic [7:0]       hb, ridx;
	logic             is_wr, credit, issue, last_sub, use_ram, res_pop, out_empty, out_full;
	logic [23:0]      dcolor, rdata, color;
	logic [DIM_W-1:0] x;
	logic [OCW-1:0]   ocnt;

	logic             valid_s1, use_ram_s1, ok_s1, last_s1, excess_s1;
	logic [23:0]      color_s1;
	logic [DIM_W-1:0] x_s1;
	bspu_pkg::res_t   res_s;
	logic [$bits(bspu_pkg::res_t)-1:0] res_bits;

	assign res_pop   = res_valid && res_ready;
	assign res_valid = !out_empty;
	assign res       = bspu_pkg::res_t'(res_bits);

	always_comb begin
		hb       = head.data[7:0];
		is_wr    = head_valid && head.kind == bspu_pkg::CMD_PAL_WR;
		// results in the buffer plus the one in flight must fit
		credit   = (int'(ocnt) + int'(valid_s1)) < (bspu_pkg::OUT_DEPTH + int'(res_pop));
		issue    = head_valid && !is_wr && credit;
		last_sub = {1'b0, sub_q} == (head.count - 4'd1);
		head_pop = is_wr || (issue && last_sub);
		use_ram  = head.kind == bspu_pkg::CMD_NIB || head.kind == bspu_pkg::CMD_IDX;
		if (head.kind == bspu_pkg::CMD_NIB) begin
			ridx = (sub_q == 3'd0) ? {4'h0, hb[7:4]} : {4'h0, hb[3:0]};
		end else begin
			ridx = hb;
		end
		case (head.kind)
			bspu_pkg::CMD_MONO: dcolor = hb[3'd7 - sub_q] ? 24'h000000 : 24'hffffff;
			bspu_pkg::CMD_RGB:  dcolor = head.data;
			default:            dcolor = '0;
		endcase
		x = head.col + {{(DIM_W-3){1'b0}}, sub_q};
	end

	bspu_ram #(
		.W     (24),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (is_wr),
		.waddr (head.index[AW-1:0]),
		.wdata (head.data),
		.re    (issue && use_ram),
		.raddr (ridx[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (head_pop) begin
				sub_q <= '0;
			end else if (issue) begin
				sub_q <= sub_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			use_ram_s1 <= use_ram;
			ok_s1      <= int'(ridx) < PALETTE_DEPTH;
			color_s1   <= dcolor;
			x_s1       <= x;
			last_s1    <= last_sub;
			excess_s1  <= head.kind == bspu_pkg::CMD_EXCESS;
		end
	end

	always_comb begin
		color = use_ram_s1 ? (ok_s1 ? rdata : 24'h000000) : color_s1;
		res_s.blue    = color[7:0];
		res_s.green   = color[15:8];
		res_s.red     = color[23:16];
		res_s.x       = x_s1[11:0];
		res_s.row_end = !excess_s1 && (({1'b0, x_s1} + (DIM_W+1)'(1)) == {1'b0, cfg.width});
		res_s.excess  = excess_s1;
		res_s.last    = last_s1;
	end

	bspu_fifo #(
		.W     ($bits(bspu_pkg::res_t)),
		.DEPTH (bspu_pkg::OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.wdata  (res_s),
		.pop    (res_pop),
		.rdata  (res_bits),
		.empty  (out_empty),
		.full   (out_full),
		.count  (ocnt)
	);

`ifndef SYNTHESIS
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_full)
		else $error("result buffer overflow");
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !is_wr |-> {1'b0, sub_q} < head.count)
		else $error("run index beyond command count");
	a_excess_blank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.excess |-> res.blue == 8'h00 && res.green == 8'h00 &&
			res.red == 8'h00 && !res.row_end && res.last)
		else $error("excess result carries pixel data");
`endif

endmodule

@@ hw/rtl/bmp_scanline_pixel_unpacker.sv @@
// Top level of the BMP scanline pixel unpacker: register port, front end,
// command queue and back end. Depends on bspu_pkg, bspu_fifo, bspu_front, bspu_back.
//
// Takes one item per cycle (palette write, pixel-array byte or counter restart)
// and emits pixels as blue/green/red with column, row-end and last-of-byte marks.
// The back end delivers one result per cycle while the result buffer has room, so
// 8-bit and 24-bit data run at one byte per cycle; a 4-bit byte gives up to two
// results and a 1-bit byte up to eight, and palette writes occupy the back end. A
// four-entry command queue between front and back absorbs these bursts, and the item
// channel stalls only when it fills. Registers: 0x0 depth_mode, 0x4 image_width,
// 0x8 image_height; write them only while idle.
module bmp_scanline_pixel_unpacker #(
	parameter int MAX_WIDTH     = bspu_pkg::MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = bspu_pkg::PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_color,
	output logic        pixel_valid,
	input  logic        pixel_ready,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red,
	output logic [11:0] pixel_x,
	output logic        row_end,
	output logic        excess_error,
	output logic        last_of_run
);

	localparam int DIM_W = bspu_pkg::DIM_W;
	localparam int CMD_W = $bits(bspu_pkg::cmd_t);

	bspu_pkg::mode_t  mode_q;
	logic [DIM_W-1:0] width_q, height_q;
	bspu_pkg::cfg_t   cfg;
	bspu_pkg::cmd_t   cmd_in, cmd_head;
	bspu_pkg::res_t   res;
	logic [CMD_W-1:0] head_bits;
	logic             cmd_push, cmd_pop, cmd_full, cmd_empty, reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bspu_pkg::MODE_RESET;
			width_q  <= bspu_pkg::WIDTH_RESET;
			height_q <= bspu_pkg::HEIGHT_RESET;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				bspu_pkg::REG_DEPTH_MODE: mode_q   <= bspu_pkg::mode_t'(pwdata[1:0]);
				bspu_pkg::REG_WIDTH:      width_q  <= pwdata[DIM_W-1:0];
				bspu_pkg::REG_HEIGHT:     height_q <= pwdata[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bspu_pkg::REG_DEPTH_MODE: prdata = {30'h0, mode_q};
			bspu_pkg::REG_WIDTH:      prdata = {{(32-DIM_W){1'b0}}, width_q};
			bspu_pkg::REG_HEIGHT:     prdata = {{(32-DIM_W){1'b0}}, height_q};
			default:                  prdata = '0;
		endcase
	end

	// zero width/height count as one, width clamps to MAX_WIDTH
	always_comb begin
		cfg.mode = mode_q;
		if (width_q == '0) begin
			cfg.width = DIM_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			cfg.width = DIM_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		cfg.height = (height_q == '0) ? DIM_W'(1) : height_q;
	end

	bspu_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.action        (action),
		.data_byte     (data_byte),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.cmd_full      (cmd_full)
	);

	bspu_fifo #(
		.W     (CMD_W),
		.DEPTH (bspu_pkg::CMD_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (head_bits),
		.empty  (cmd_empty),
		.full   (cmd_full),
		.count  ()
	);

	assign cmd_head = bspu_pkg::cmd_t'(head_bits);

	bspu_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (!cmd_empty),
		.head       (cmd_head),
		.head_pop   (cmd_pop),
		.res_valid  (pixel_valid),
		.res_ready  (pixel_ready),
		.res        (res)
	);

	assign blue         = res.blue;
	assign green        = res.green;
	assign red          = res.red;
	assign pixel_x      = res.x;
	assign row_end      = res.row_end;
	assign excess_error = res.excess;
	assign last_of_run  = res.last;

endmodule
